@@ hdl/iida_pkg.sv @@
`timescale 1ns / 1ps

package iida_pkg;

	localparam int OP_W   = 2;
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;

	localparam logic [OP_W-1:0] OP_READ   = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

@@ hdl/iida_req_if.sv @@
`timescale 1ns / 1ps

interface iida_req_if;
	import iida_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] write_value;

	modport source (output valid, output op, output position, output write_value, input ready);
	modport sink (input valid, input op, input position, input write_value, output ready);

endinterface

@@ hdl/iida_rsp_if.sv @@
`timescale 1ns / 1ps

interface iida_rsp_if;
	import iida_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]         count;
	status_t                  status;

	modport source (output valid, output read_value, output count, output status, input ready);
	modport sink (input valid, input read_value, input count, input status, output ready);

endinterface

@@ hdl/indexed_insert_delete_array.sv @@
`timescale 1ns / 1ps

// channel  dir  fields
// req      in   op, position, write_value
// rsp      out  read_value, count, status
//
// two register stages: req is captured in s1, the operation runs combinationally
// from s1 into the cells and the s2 result register, so one transaction a cycle
// is sustained while rsp is ready
// every cell picks hold, left neighbor, right neighbor or the new value in parallel
// arst_n clears the valid flags and the element count; cell contents are not reset
// a stalled rsp holds s2, s1 holds behind it and req.ready drops only when both are full

module indexed_insert_delete_array #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	iida_req_if.sink   req,
	iida_rsp_if.source rsp
);
	import iida_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	// input stage
	logic                  valid_s1;
	logic [OP_W-1:0]       op_s1;
	logic [POS_W-1:0]      position_s1;
	logic [DATA_W-1:0]     write_value_s1;

	// result stage
	logic                  valid_s2;
	logic [DATA_W-1:0]     read_value_s2;
	logic [CNT_W-1:0]      count_s2;
	status_t               status_s2;

	logic [VALUE_BITS-1:0] cells_q [CAPACITY];
	logic [VALUE_BITS-1:0] cells_d [CAPACITY];
	logic [VALUE_BITS-1:0] left_nb [CAPACITY];
	logic [VALUE_BITS-1:0] right_nb [CAPACITY];
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;

	logic                  load_s2;
	logic                  advance;
	logic                  full;
	logic                  empty;
	logic [PW-1:0]         pos_ext;
	logic [PW-1:0]         cnt_ext;
	logic [PW-1:0]         last_ext;
	logic [IW-1:0]         ins_idx;
	logic [IW-1:0]         del_idx;
	logic [VALUE_BITS-1:0] wv_store;
	logic [VALUE_BITS-1:0] rd_cell;
	logic [DATA_W-1:0]     rd_word;
	logic [DATA_W-1:0]     read_value_d;
	status_t               status_d;

	assign load_s2   = !valid_s2 || rsp.ready;
	assign advance   = valid_s1 && load_s2;
	assign req.ready = !valid_s1 || load_s2;

	assign rsp.valid      = valid_s2;
	assign rsp.read_value = read_value_s2;
	assign rsp.count      = count_s2;
	assign rsp.status     = status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1          <= req.op;
			position_s1    <= req.position;
			write_value_s1 <= req.write_value;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_nb
		if (g == 0) begin : g_first
			assign left_nb[g] = cells_q[g];
		end else begin : g_mid_l
			assign left_nb[g] = cells_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_nb[g] = cells_q[g];
		end else begin : g_mid_r
			assign right_nb[g] = cells_q[g+1];
		end
	end

	// stored width may differ from the 32-bit port
	if (VALUE_BITS <= DATA_W) begin : g_narrow_wr
		assign wv_store = write_value_s1[VALUE_BITS-1:0];
	end else begin : g_wide_wr
		assign wv_store = {{(VALUE_BITS - DATA_W){1'b0}}, write_value_s1};
	end

	assign rd_cell = cells_q[pos_ext[IW-1:0]];

	if (VALUE_BITS >= DATA_W) begin : g_wide_rd
		assign rd_word = rd_cell[DATA_W-1:0];
	end else begin : g_narrow_rd
		assign rd_word = {{(DATA_W - VALUE_BITS){rd_cell[VALUE_BITS-1]}}, rd_cell};
	end

	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign pos_ext  = PW'(position_s1);
	assign cnt_ext  = PW'(count_q);
	assign last_ext = cnt_ext - PW'(1);
	assign ins_idx  = IW'((pos_ext > cnt_ext) ? cnt_ext : pos_ext);
	assign del_idx  = IW'((pos_ext > last_ext) ? last_ext : pos_ext);

	always_comb begin
		cells_d      = cells_q;
		count_d      = count_q;
		status_d     = ST_OK;
		read_value_d = '0;
		case (op_s1)
			OP_READ: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					status_d = ST_RANGE;
				end else begin
					read_value_d = rd_word;
				end
			end
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (IW'(i) == ins_idx) begin
							cells_d[i] = wv_store;
						end else if (IW'(i) > ins_idx) begin
							cells_d[i] = left_nb[i];
						end
					end
					count_d = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (IW'(i) >= del_idx) begin
							cells_d[i] = right_nb[i];
						end
					end
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cells_q <= cells_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				count_q <= count_d;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_value_s2 <= read_value_d;
			count_s2      <= CNT_W'(count_d);
			status_s2     <= status_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_INSERT && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the array");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_DELETE && !empty |=> count_q == $past(count_q) - CW'(1))
		else $error("delete did not shrink the array");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 == ST_FULL |-> count_q == CW'(CAPACITY))
		else $error("full status while array not full");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 != ST_OK |-> read_value_s2 == '0)
		else $error("nonzero read value on error");

endmodule

@@ dv/indexed_insert_delete_array_tb.sv @@
`timescale 1ns / 1ps

module indexed_insert_delete_array_tb;
	import iida_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int VALUE_BITS  = 32;
	localparam int CLK_PERIOD  = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_LIMIT = 100;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         count;
		status_t                  status;
	} rsp_fields_t;

	logic clk = 1'b0;
	logic arst_n;

	iida_req_if req_ch ();
	iida_rsp_if rsp_ch ();

	indexed_insert_delete_array #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the array contents, in logical order
	logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
	int                       shadow_len = 0;
	rsp_fields_t              awaited_rsp [$];

	int  send_idle_pct = 14;
	int  recv_idle_pct = 83;
	bit  quiet_stretch = 1'b0;
	int  err_count     = 0;
	int  results_seen  = 0;
	int  cycle_count   = 0;
	int  op_hits [4]   = '{0, 0, 0, 0};
	int  full_refusals = 0;
	int  empty_refusals = 0;
	int  range_reads   = 0;
	int  peak_len      = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic rsp_fields_t apply_array_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic signed [DATA_W-1:0] wval);
		rsp_fields_t r;
		int          p;
		r.read_value = '0;
		r.status     = ST_OK;
		p            = pos;
		op_hits[op]++;
		case (op)
			OP_READ: begin
				if (shadow_len == 0) begin
					r.status = ST_EMPTY;
					empty_refusals++;
				end else if (p >= shadow_len) begin
					r.status = ST_RANGE;
					range_reads++;
				end else begin
					r.read_value = shadow_cells[p];
				end
			end
			OP_INSERT: begin
				if (shadow_len >= CAPACITY) begin
					r.status = ST_FULL;
					full_refusals++;
				end else begin
					// positions past the end append
					if (p > shadow_len)
						p = shadow_len;
					for (int i = shadow_len; i > p; i--)
						shadow_cells[i] = shadow_cells[i - 1];
					shadow_cells[p] = wval;
					shadow_len++;
				end
			end
			OP_DELETE: begin
				if (shadow_len == 0) begin
					r.status = ST_EMPTY;
					empty_refusals++;
				end else begin
					// positions at or past the last element remove the last one
					if (p > shadow_len - 1)
						p = shadow_len - 1;
					for (int i = p; i + 1 < shadow_len; i++)
						shadow_cells[i] = shadow_cells[i + 1];
					shadow_len--;
				end
			end
			default: ;
		endcase
		if (shadow_len > peak_len)
			peak_len = shadow_len;
		r.count = shadow_len[CNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		if (err_count < PRINT_LIMIT)
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_seen, what, got, want);
		err_count++;
	endtask

	// one transaction on req; valid stays high afterwards unless the next call idles
	task automatic send_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic signed [DATA_W-1:0] wval);
		int gap;
		if (!quiet_stretch && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(3, 1);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.op          <= op;
		req_ch.position    <= pos;
		req_ch.write_value <= wval;
		do @(posedge clk); while (!req_ch.ready);
		awaited_rsp.push_back(apply_array_op(op, pos, wval));
	endtask

	always @(posedge clk)
		rsp_ch.ready <= quiet_stretch || ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		rsp_fields_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_rsp.size() == 0) begin
				report_mismatch("transaction with nothing awaited, count", rsp_ch.count, 0);
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp_ch.read_value !== want.read_value)
					report_mismatch("read_value", rsp_ch.read_value, want.read_value);
				if (rsp_ch.count !== want.count)
					report_mismatch("count", rsp_ch.count, want.count);
				if (rsp_ch.status !== want.status)
					report_mismatch("status", rsp_ch.status, want.status);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_rsp.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic test_empty_array;
		send_op(OP_READ, 5'd0, 32'sd0);
		send_op(OP_READ, 5'd31, 32'sd0);
		send_op(OP_DELETE, 5'd0, 32'sd0);
		send_op(OP_DELETE, 5'd31, 32'sd0);
		send_op(OP_UNUSED, 5'd31, 32'h7fff_ffff);
	endtask

	task automatic test_insert_and_read;
		// builds min, 0, -1, max
		send_op(OP_INSERT, 5'd31, 32'h7fff_ffff);
		send_op(OP_INSERT, 5'd0, 32'h8000_0000);
		send_op(OP_INSERT, 5'd1, 32'h0000_0000);
		send_op(OP_INSERT, 5'd2, 32'hffff_ffff);
		send_op(OP_READ, 5'd0, 32'sd0);
		send_op(OP_READ, 5'd3, 32'sd0);
		send_op(OP_READ, 5'd4, 32'sd0);
		send_op(OP_READ, 5'd31, 32'sd0);
		send_op(OP_DELETE, 5'd1, 32'sd0);
	endtask

	task automatic test_full_and_delete;
		while (shadow_len < CAPACITY)
			send_op(OP_INSERT, 5'($urandom_range(shadow_len, 0)), $urandom);
		send_op(OP_INSERT, 5'd3, 32'h1234_5678);
		send_op(OP_READ, 5'(CAPACITY - 1), 32'sd0);
		send_op(OP_DELETE, 5'd31, 32'sd0);
		send_op(OP_DELETE, 5'd0, 32'sd0);
	endtask

	task automatic run_random_traffic(int n_items, int s_pct, int r_pct);
		int                       insert_bias;
		int                       roll;
		logic [OP_W-1:0]          op;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] wval;
		insert_bias   = 50;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int k = 0; k < n_items; k++) begin
			// drift between filling and draining so full and empty both get hit
			if (k % 40 == 0)
				insert_bias = 20 + 30 * $urandom_range(2, 0);
			quiet_stretch = (k % 80) >= 64;
			roll = $urandom_range(99);
			if (roll < 3)
				op = OP_UNUSED;
			else if (roll < 33)
				op = OP_READ;
			else if ($urandom_range(99) < insert_bias)
				op = OP_INSERT;
			else
				op = OP_DELETE;
			if ($urandom_range(99) < 15)
				pos = POS_W'($urandom_range(31, 0));
			else
				pos = POS_W'($urandom_range(shadow_len + 1, 0));
			roll = $urandom_range(99);
			if (roll < 3)
				wval = 32'h7fff_ffff;
			else if (roll < 6)
				wval = 32'h8000_0000;
			else if (roll < 8)
				wval = 32'hffff_ffff;
			else if (roll < 10)
				wval = '0;
			else
				wval = $urandom;
			send_op(op, pos, wval);
		end
		quiet_stretch = 1'b0;
	endtask

	task automatic test_random_traffic;
		run_random_traffic(630, 14, 83);
		run_random_traffic(630, 83, 14);
		run_random_traffic(640, 0, 0);
	endtask

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.op          = OP_READ;
		req_ch.position    = '0;
		req_ch.write_value = '0;
		rsp_ch.ready       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_array();
		test_insert_and_read();
		test_full_and_delete();
		test_random_traffic();

		req_ch.valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d transactions: %0d reads, %0d inserts, %0d deletes, %0d unused op",
			results_seen, op_hits[OP_READ], op_hits[OP_INSERT], op_hits[OP_DELETE],
			op_hits[OP_UNUSED]);
		$display("refused %0d full inserts, %0d empty ops, %0d range reads; peak length %0d",
			full_refusals, empty_refusals, range_reads, peak_len);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/iida_pkg.sv
hdl/iida_req_if.sv
hdl/iida_rsp_if.sv
hdl/indexed_insert_delete_array.sv
dv/indexed_insert_delete_array_tb.sv
